// File: src/chte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chte_pkg;
    localparam int NumBucketsDef = 256;
    localparam int NumNodesDef   = 256;
    localparam int KeyBytesDef   = 8;
    localparam int ValueBitsDef  = 32;
    localparam logic [31:0] HashSeed = 32'd5381;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpLookup = 2'd1;
    localparam logic [1:0] OpRemove = 2'd2;

    localparam logic [1:0] StDone    = 2'd0;
    localparam logic [1:0] StMissing = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key_bytes;
        logic [3:0]  key_len;
        logic [31:0] value_handle;
        logic [15:0] value_len;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [15:0] found_len;
        logic [8:0]  entry_count;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_MOD, S_HEAD, S_HEADW, S_NODE, S_CMP, S_UNLINK, S_FREEP, S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: src/chte_hash_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// Hashes one key byte per cycle, then reduces by restoring division one bit per cycle.
module chte_hash_mod #(
    parameter int BW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [63:0]   i_key,
    input  wire logic [3:0]    i_len,
    input  wire logic [BW:0]   i_div,
    output logic               o_done,
    output logic [BW-1:0]      o_bucket
);
    import chte_pkg::*;
    logic        r_busy, n_busy;
    logic        r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_h, n_h;
    logic [BW:0] r_rem, n_rem;
    logic        r_done, n_done;
    logic [BW+1:0] w_trial;

    always_comb begin
        n_busy = r_busy; n_phase = r_phase; n_cnt = r_cnt; n_h = r_h;
        n_rem = r_rem; n_done = 1'b0;
        w_trial = {r_rem, r_h[31]} - {1'b0, i_div};
        if (i_go) begin
            n_busy = 1'b1; n_phase = 1'b0; n_cnt = 6'd0; n_h = HashSeed;
            n_rem = '0;
        end else if (r_busy && !r_phase) begin
            if (r_cnt[3:0] >= i_len) begin
                n_phase = 1'b1; n_cnt = 6'd0;
            end else begin
                n_h = (r_h + (r_h << 5)) ^ {24'd0, i_key[r_cnt[2:0]*8 +: 8]};
                n_cnt = r_cnt + 6'd1;
            end
        end else if (r_busy) begin
            if (!w_trial[BW+1]) n_rem = w_trial[BW:0];
            else n_rem = {r_rem[BW-1:0], r_h[31]};
            n_h = {r_h[30:0], 1'b0};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_phase <= n_phase; r_cnt <= n_cnt; r_h <= n_h; r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BW-1:0];
endmodule
`default_nettype wire

// File: src/chained_hash_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Chained hash table engine.
// A command beat is taken when i_start is high and o_busy is low. It carries
// an opcode (insert, lookup, remove), a key of up to eight bytes and, for an
// insert, a value handle and length. Exactly one result beat follows, shown
// for a single cycle with o_done high; the receiver cannot hold it off.
// The key is hashed one byte per cycle, reduced modulo the bucket count by a
// one-bit-per-cycle divider, then the bucket head memory is read and, for
// lookup or remove, the chain is walked node by node through the node
// memory's single read port. The key length is capped at eight. An insert
// that reuses a freed node passes through an extra state that pops the free
// list, and a remove hit through one that pushes the removed node onto it.
// o_busy drops in the result cycle, so the next command beat can be taken
// at the edge that takes the result.
// Reset empties the table at once: the bucket heads carry a valid bit per
// bucket, so no clearing pass is needed. Node storage needs no reset.
// i_cfg_we writes the bucket count (taken as 1 when zero and capped at the
// bucket memory size); the user must write it only while the engine is idle (not checked).
module chained_hash_table_engine #(
    parameter int NUM_BUCKETS = chte_pkg::NumBucketsDef,
    parameter int NUM_NODES   = chte_pkg::NumNodesDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire chte_pkg::t_req i_req,
    output logic                o_busy,
    output logic                o_done,
    output chte_pkg::t_rsp      o_rsp,
    input  wire logic           i_cfg_we,
    input  wire logic [8:0]     i_cfg_wdata
);
    import chte_pkg::*;
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int NW = $clog2(NUM_NODES + 1);
    localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam logic [NW-1:0] Nil = NW'(NUM_NODES);
    localparam int CW = 13;

    typedef struct packed {
        logic [NW-1:0] next;
        logic [63:0]   key;
        logic [3:0]    klen;
        logic [31:0]   val;
        logic [15:0]   vlen;
    } t_node;

    t_node          m_node [NUM_NODES];
    logic [NW-1:0]  m_head [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_hvalid;

    t_state r_state, n_state;
    t_req   r_req;
    logic [8:0]    r_bcount;
    logic [NW-1:0] r_free, r_fresh, r_cur, r_prev, r_headq;
    logic [8:0]    r_count;
    logic [CW-1:0] r_steps;
    t_node         r_nq;
    t_rsp          r_rsp;
    logic          r_done;
    logic [BW-1:0] r_bucket;
    logic [3:0]    w_len;
    logic [63:0]   w_key;
    logic [BW:0]   w_div;
    logic          w_hdone;
    logic [BW-1:0] w_bucket;
    logic          w_match, w_full;
    logic [NW-1:0] w_alloc;

    always_comb begin
        w_len = (r_req.key_len > 4'd8) ? 4'd8 : r_req.key_len;
        w_key = (w_len == 4'd8) ? r_req.key_bytes
              : r_req.key_bytes & ((64'd1 << {w_len[2:0], 3'd0}) - 64'd1);
        if (r_bcount == 9'd0) w_div = (BW+1)'(1);
        else if (32'(r_bcount) > NUM_BUCKETS) w_div = (BW+1)'(NUM_BUCKETS);
        else w_div = (BW+1)'(r_bcount);
    end

    chte_hash_mod #(.BW(BW)) u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_state == S_HASH),
        .i_key(w_key), .i_len(w_len), .i_div(w_div),
        .o_done(w_hdone), .o_bucket(w_bucket));

    assign w_match = (r_nq.klen == w_len) && (r_nq.key == w_key);
    assign w_full  = (r_free == Nil) && (r_fresh == Nil);
    assign w_alloc = (r_free != Nil) ? r_free : r_fresh;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_HASH;
            S_HASH:   n_state = S_MOD;
            S_MOD:    if (w_hdone) n_state = S_HEAD;
            S_HEAD:   n_state = S_HEADW;
            S_HEADW: begin
                if (r_req.opcode == OpInsert) begin
                    n_state = (r_free != Nil) ? S_FREEP : S_DONE;
                end else n_state = S_NODE;
            end
            S_NODE:   n_state = (r_cur == Nil || 32'(r_steps) >= NUM_NODES) ? S_DONE : S_CMP;
            S_CMP: begin
                if (w_match) n_state = (r_req.opcode == OpRemove) ? S_UNLINK : S_DONE;
                else n_state = S_NODE;
            end
            S_UNLINK: n_state = S_DONE;
            S_FREEP:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_done = r_done;
        o_rsp  = r_rsp;
    end

    // Head memory: registered read, write-back with a per-bucket valid bit.
    always_ff @(posedge i_clk) begin
        if (r_state == S_HEAD) r_headq <= m_head[w_bucket];
        if (r_state == S_MOD && w_hdone) r_bucket <= w_bucket;
        if (r_state == S_HEADW && r_req.opcode == OpInsert && !w_full)
            m_head[r_bucket] <= w_alloc;
        if (r_state == S_CMP && w_match && r_req.opcode == OpRemove && r_prev == Nil)
            m_head[r_bucket] <= r_nq.next;
    end

    logic [NW-1:0] w_head;
    assign w_head = r_hvalid[r_bucket] ? r_headq : Nil;

    // Node memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_NODE && r_cur != Nil) r_nq <= m_node[r_cur[AW-1:0]];
        if (r_state == S_HEADW && r_req.opcode == OpInsert && r_free != Nil)
            r_nq <= m_node[r_free[AW-1:0]];
        if (r_state == S_HEADW && r_req.opcode == OpInsert && !w_full)
            m_node[w_alloc[AW-1:0]] <= '{next: w_head, key: w_key, klen: w_len,
                val: r_req.value_handle, vlen: r_req.value_len};
        if (r_state == S_CMP && w_match && r_req.opcode == OpRemove && r_prev != Nil)
            m_node[r_prev[AW-1:0]].next <= r_nq.next;
        if (r_state == S_UNLINK) m_node[r_cur[AW-1:0]].next <= r_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_bcount <= 9'd32; r_free <= Nil; r_fresh <= '0;
            r_count <= '0; r_hvalid <= '0; r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) r_bcount <= i_cfg_wdata;
            case (r_state)
                S_HEADW: begin
                    r_cur <= w_head; r_prev <= Nil; r_steps <= '0;
                    if (r_req.opcode == OpInsert && !w_full) begin
                        r_hvalid[r_bucket] <= 1'b1;
                        r_count <= r_count + 9'd1;
                        r_rsp <= '{status: StDone, found_value: 32'd0, found_len: 16'd0,
                                   entry_count: r_count + 9'd1};
                        if (r_free == Nil) r_fresh <= (32'(r_fresh) + 1 >= NUM_NODES)
                            ? Nil : r_fresh + NW'(1);
                    end else begin
                        r_rsp <= '{status: (r_req.opcode == OpInsert) ? StFull : StDone,
                                   found_value: 32'd0, found_len: 16'd0,
                                   entry_count: r_count};
                    end
                end
                S_NODE: if (r_cur == Nil || 32'(r_steps) >= NUM_NODES)
                    r_rsp.status <= StMissing;
                S_CMP: begin
                    if (w_match) begin
                        if (r_req.opcode == OpRemove) begin
                            if (r_count != 9'd0) begin
                                r_count <= r_count - 9'd1;
                                r_rsp.entry_count <= r_count - 9'd1;
                            end
                        end else begin
                            r_rsp <= '{status: StDone, found_value: r_nq.val,
                                       found_len: r_nq.vlen, entry_count: r_count};
                        end
                    end else begin
                        r_prev <= r_cur; r_cur <= r_nq.next; r_steps <= r_steps + CW'(1);
                    end
                end
                S_UNLINK: r_free <= r_cur;
                S_FREEP:  r_free <= r_nq.next;
                S_DONE:   r_done <= 1'b1;
                default: ;
            endcase
        end
        if (r_state == S_IDLE && i_start) r_req <= i_req;
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= NUM_NODES) else $error("entry count overflow");
endmodule
`default_nettype wire
